@@ hw/rtl/udwc_pkg.sv @@
package udwc_pkg;

    localparam int MAX_LEVELS_DEF = 8;
    localparam int DATA_WIDTH_DEF = 24;
    localparam int TAPS           = 4;
    localparam int HIST_DEPTH     = TAPS - 1;
    localparam int SAMPLE_W       = 16;
    localparam int LEVEL_W        = 4;
    localparam int COEF_W         = 16;
    localparam int FRAC_BITS      = 15;
    localparam int MAC_STEPS      = 2 * TAPS;
    localparam int STEP_W         = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd3;

    // Q1.15 D4 taps: steps 0..3 low-pass, steps 4..7 high-pass
    function automatic logic signed [COEF_W-1:0] coef(input logic [2:0] step);
        logic signed [COEF_W-1:0] c;
        case (step)
            3'd0:    c = 16'sd15826;
            3'd1:    c = 16'sd27411;
            3'd2:    c = 16'sd7345;
            3'd3:    c = -16'sd4240;
            3'd4:    c = -16'sd4240;
            3'd5:    c = -16'sd7345;
            3'd6:    c = 16'sd27411;
            default: c = -16'sd15826;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/undecimated_db4_wavelet_cascade.sv @@
// Undecimated Daubechies-4 wavelet cascade over complex samples.
//
// Input stream (s_axis_*): one complex sample per word, tuser marks the first
// sample of a new signal and clears every stage history before it is used.
// Output stream (m_axis_*): for each sample, one detail word per active level
// in level order, then the final approximation word with tlast high.
// cfg_we/cfg_wdata set the level count (reset 3, clamped to MAX_LEVELS).
//
// Each level runs on one shared complex multiply-accumulate unit: a history
// row read, then the eight taps (low-pass and high-pass) with a product
// register in between, then round/saturate and history write-back, then the
// hand-off of the detail word to the output register. s_axis_tready is high
// only between samples.
// The history is one row per level in a small RAM; per-row valid bits make
// an unwritten or cleared row read as zero, so reset needs no clearing pass.
// When the receiver stalls, the sequencer holds at the next result until the
// output register frees up; a new sample can be taken while the last
// approximation word still waits.
module undecimated_db4_wavelet_cascade #(
    parameter int MAX_LEVELS = udwc_pkg::MAX_LEVELS_DEF,
    parameter int DATA_WIDTH = udwc_pkg::DATA_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // sample_re[15:0], sample_im[31:16]
    input  logic        s_axis_tuser,  // first_sample

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // level_index, value_re, value_im, zero pad
    output logic [((udwc_pkg::LEVEL_W + 2*DATA_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic                 m_axis_tuser,  // is_approx
    output logic                 m_axis_tlast,  // last_of_run

    input  logic                          cfg_we,
    input  logic [udwc_pkg::LEVEL_W-1:0]  cfg_wdata
);

    localparam int DW     = DATA_WIDTH;
    localparam int LW     = udwc_pkg::LEVEL_W;
    localparam int OUT_W  = ((LW + 2*DW + 7) / 8) * 8;
    localparam int PAD_W  = OUT_W - LW - 2*DW;
    localparam int PROD_W = DW + udwc_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SH_W   = ACC_W + 1 - udwc_pkg::FRAC_BITS;
    localparam int ROW_W  = udwc_pkg::HIST_DEPTH * 2 * DW;
    localparam int IDX_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SW     = udwc_pkg::SAMPLE_W;
    localparam int STW    = udwc_pkg::STEP_W;

    localparam logic [LW-1:0]  MAX_LVL   = LW'(MAX_LEVELS);
    localparam logic [STW-1:0] LAST_STEP = STW'(udwc_pkg::MAC_STEPS);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_MAC    = 3'd2;
    localparam logic [2:0] ST_FIN    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;
    localparam logic [2:0] ST_APPROX = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [LW-1:0]         level_count_reg;
    logic [LW-1:0]         levels_reg;
    logic [LW-1:0]         stage_reg;
    logic [STW-1:0]        step_reg;
    logic [MAX_LEVELS-1:0] row_valid_reg;

    logic signed [DW-1:0]     cur_re_reg, cur_im_reg;
    logic signed [DW-1:0]     det_re_reg, det_im_reg;
    logic signed [PROD_W-1:0] prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]  acc_lo_re_reg, acc_lo_im_reg, acc_hi_re_reg, acc_hi_im_reg;

    logic [ROW_W-1:0] hist_mem [MAX_LEVELS];
    logic [ROW_W-1:0] rd_row_reg;
    logic             rd_valid_reg;

    logic             out_valid_reg;
    logic [LW-1:0]    out_level_reg;
    logic             out_approx_reg;
    logic             out_last_reg;
    logic [DW-1:0]    out_re_reg, out_im_reg;

    logic                     in_fire;
    logic                     out_free;
    logic [IDX_W-1:0]         idx;
    logic [ROW_W-1:0]         hist_row;
    logic signed [DW-1:0]     tap_re, tap_im;
    logic signed [udwc_pkg::COEF_W-1:0] coef_w;
    logic signed [PROD_W-1:0] mul_re, mul_im;
    logic signed [ACC_W-1:0]  prod_re_ext, prod_im_ext;
    logic [2:0]               pidx;
    logic [LW-1:0]            levels_clamped;
    logic signed [DW-1:0]     lo_re, lo_im, hi_re, hi_im;
    logic signed [SW-1:0]     in_re, in_im;

    // Round half up, drop the fraction, saturate to DW bits
    function automatic logic signed [DW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] sum;
        logic [SH_W-1:0]       sh;
        logic [SH_W-DW:0]      top;
        logic signed [DW-1:0]  r;
        sum = {a[ACC_W-1], a} + (ACC_W+1)'(1 << (udwc_pkg::FRAC_BITS - 1));
        sh  = sum[ACC_W:udwc_pkg::FRAC_BITS];
        top = sh[SH_W-1:DW-1];
        if ((&top) || !(|top))
            r = sh[DW-1:0];
        else if (sh[SH_W-1])
            r = {1'b1, {(DW-1){1'b0}}};
        else
            r = {1'b0, {(DW-1){1'b1}}};
        return r;
    endfunction

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign idx      = stage_reg[IDX_W-1:0];
    assign hist_row = rd_valid_reg ? rd_row_reg : '0;
    assign in_re    = s_axis_tdata[SW-1:0];
    assign in_im    = s_axis_tdata[2*SW-1:SW];
    assign pidx     = 3'(step_reg - STW'(1));

    assign levels_clamped = (int'(level_count_reg) > MAX_LEVELS) ? MAX_LVL : level_count_reg;

    // Tap 0 is the current stage input, taps 1..3 come from the history row
    always_comb
    begin
        if (step_reg[1:0] == 2'd0)
        begin
            tap_re = cur_re_reg;
            tap_im = cur_im_reg;
        end
        else
        begin
            tap_re = hist_row[(int'(step_reg[1:0]) - 1) * 2 * DW +: DW];
            tap_im = hist_row[(int'(step_reg[1:0]) - 1) * 2 * DW + DW +: DW];
        end
        coef_w = udwc_pkg::coef(step_reg[2:0]);
        mul_re = coef_w * tap_re;
        mul_im = coef_w * tap_im;
        prod_re_ext = {{2{prod_re_reg[PROD_W-1]}}, prod_re_reg};
        prod_im_ext = {{2{prod_im_reg[PROD_W-1]}}, prod_im_reg};
        lo_re = round_sat(acc_lo_re_reg);
        lo_im = round_sat(acc_lo_im_reg);
        hi_re = round_sat(acc_hi_re_reg);
        hi_im = round_sat(acc_hi_im_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (levels_clamped == '0) ? ST_APPROX : ST_READ;
            end
            ST_READ:   state_next = ST_MAC;
            ST_MAC:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_FIN;
            end
            ST_FIN:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = (stage_reg + LW'(1) == levels_reg) ? ST_APPROX : ST_READ;
            end
            ST_APPROX:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            level_count_reg <= udwc_pkg::LEVEL_RESET;
            levels_reg      <= '0;
            stage_reg       <= '0;
            step_reg        <= '0;
            row_valid_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                level_count_reg <= cfg_wdata;
            if (out_free && (state_reg == ST_EMIT || state_reg == ST_APPROX))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        levels_reg <= levels_clamped;
                        stage_reg  <= '0;
                        if (s_axis_tuser)
                            row_valid_reg <= '0;
                    end
                end
                ST_READ:   step_reg <= '0;
                ST_MAC:    step_reg <= step_reg + STW'(1);
                ST_FIN:    row_valid_reg[idx] <= 1'b1;
                ST_EMIT:
                begin
                    if (out_free)
                        stage_reg <= stage_reg + LW'(1);
                end
                default:   step_reg <= '0;
            endcase
        end
    end

    // History RAM: one row of three complex words per level
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN)
            hist_mem[idx] <= {hist_row[ROW_W-2*DW-1:0], cur_im_reg, cur_re_reg};
        rd_row_reg <= hist_mem[idx];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            rd_valid_reg <= row_valid_reg[idx];

        if (in_fire)
        begin
            cur_re_reg <= {{(DW-SW){in_re[SW-1]}}, in_re};
            cur_im_reg <= {{(DW-SW){in_im[SW-1]}}, in_im};
        end

        if (state_reg == ST_MAC)
        begin
            if (step_reg < LAST_STEP)
            begin
                prod_re_reg <= mul_re;
                prod_im_reg <= mul_im;
            end
            // accumulate the product of the previous step
            if (step_reg != '0)
            begin
                if (!pidx[2])
                begin
                    acc_lo_re_reg <= (pidx[1:0] == 2'd0) ? prod_re_ext : acc_lo_re_reg + prod_re_ext;
                    acc_lo_im_reg <= (pidx[1:0] == 2'd0) ? prod_im_ext : acc_lo_im_reg + prod_im_ext;
                end
                else
                begin
                    acc_hi_re_reg <= (pidx[1:0] == 2'd0) ? prod_re_ext : acc_hi_re_reg + prod_re_ext;
                    acc_hi_im_reg <= (pidx[1:0] == 2'd0) ? prod_im_ext : acc_hi_im_reg + prod_im_ext;
                end
            end
        end

        // approximation feeds the next level
        if (state_reg == ST_FIN)
        begin
            cur_re_reg <= lo_re;
            cur_im_reg <= lo_im;
            det_re_reg <= hi_re;
            det_im_reg <= hi_im;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            out_level_reg  <= stage_reg;
            out_approx_reg <= 1'b0;
            out_last_reg   <= 1'b0;
            out_re_reg     <= det_re_reg;
            out_im_reg     <= det_im_reg;
        end
        else if (state_reg == ST_APPROX && out_free)
        begin
            out_level_reg  <= levels_reg;
            out_approx_reg <= 1'b1;
            out_last_reg   <= 1'b1;
            out_re_reg     <= cur_re_reg;
            out_im_reg     <= cur_im_reg;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_im_reg, out_re_reg, out_level_reg};
    assign m_axis_tuser  = out_approx_reg;
    assign m_axis_tlast  = out_last_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("block took a word while a sample is in work");

    a_last_is_approx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("tlast and approximation flag disagree");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (step_reg <= LAST_STEP))
        else $error("tap counter ran past the last tap");

    a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (stage_reg < levels_reg))
        else $error("level counter ran past the active level count");

endmodule
